// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the blend accumulator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, muted while rst_n is low
`define FBA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// checked on every rising edge, reset included
`define FBA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/fba_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fba_pkg
// constants and types of the feather blend accumulator
// ---------------------------------------------------------------------------
package fba_pkg;

    localparam int FRAME_PIXELS_DEF = 65536;

    localparam int IDX_W   = 16;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int DIST_W  = 10;
    localparam int SHARP_W = 24;

    localparam logic [SHARP_W-1:0] SHARPNESS_RESET = 24'd1311;

    // weight in q16, 1.0 included
    localparam int W_W = 17;
    localparam logic [W_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam int PROD_W = DIST_W + SHARP_W;

    localparam int TERM_W = CH_W + W_W;
    localparam int SUM_W  = 29;
    localparam int WT_W   = 21;

    // rounded division: num = 2*sum + den, divisor = 2*den
    localparam int DEN_W = WT_W + 1;
    localparam int DIV_W = DEN_W + 1;
    localparam int NUM_W = SUM_W + 2;
    localparam int DIV_STAGES = CH_W + 1;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = IDX_W + NUM_CH * CH_W;

    // must exceed the number of items the pipeline can hold
    localparam int OUT_FIFO_DEPTH = 16;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   chan_vec_t;
    typedef logic [NUM_CH-1:0][TERM_W-1:0] term_vec_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0]  sum_vec_t;
    typedef logic [NUM_CH-1:0][NUM_W-1:0]  num_vec_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        chan_vec_t        ch;
    } result_t;

endpackage

// ===== src/fba_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fba_ram
// simple dual-port ram, one write and one registered read, read-first
// ---------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/feather_blend_accumulator.sv =====
`timescale 1ns / 1ps
// path: a result passes stages a, c, p and q, the divider stages and the output fifo on its way to m_axis
// throughput: one item per cycle while s_axis_tready is high; set by the single read-modify-write pass
//   over the sum memories and the 9-stage pipelined divider
// s_axis_tready drops only while 16 results are outstanding between s_axis and m_axis
// reset: rst_n clears the pipeline, fifo and credit count and loads
//   sharpness with 1311; the sum memories are not cleared
// ---------------------------------------------------------------------------
// feather_blend_accumulator
// per-pixel weighted sums of overlapping images, normalised on the last image
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module feather_blend_accumulator #(
    parameter int FRAME_PIXELS = fba_pkg::FRAME_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: pixel_index[15:0], first_channel[23:16], second_channel[31:24],
    //        third_channel[39:32], edge_distance[49:40], zero fill
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: first_image
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    // tdata: out_index[15:0], out_first[23:16], out_second[31:24],
    //        out_third[39:32]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fba_pkg::SHARP_W-1:0]     cfg_data
);

    localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int FIFO_AW = $clog2(fba_pkg::OUT_FIFO_DEPTH);
    localparam int CNT_W   = $clog2(fba_pkg::OUT_FIFO_DEPTH + 1);
    localparam int NCH     = fba_pkg::NUM_CH;
    localparam int NDS     = fba_pkg::DIV_STAGES;

    // ---------------- input side and configuration ----------------
    logic [fba_pkg::SHARP_W-1:0] sharpness_reg;
    logic                        in_accept;
    logic                        in_frame;
    logic [fba_pkg::IDX_W-1:0]   in_idx;
    logic [fba_pkg::DIST_W-1:0]  in_dist;
    fba_pkg::chan_vec_t          in_ch;
    logic [fba_pkg::PROD_W-1:0]  in_prod;
    logic [fba_pkg::W_W-1:0]     in_w;

    assign cfg_ready = 1'b1;
    assign in_idx    = s_axis_tdata[15:0];
    assign in_ch[0]  = s_axis_tdata[23:16];
    assign in_ch[1]  = s_axis_tdata[31:24];
    assign in_ch[2]  = s_axis_tdata[39:32];
    assign in_dist   = s_axis_tdata[49:40];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_frame  = (32'(in_idx) < 32'(FRAME_PIXELS));

    always_comb
    begin
        in_prod = fba_pkg::PROD_W'(in_dist) * fba_pkg::PROD_W'(sharpness_reg);
        in_w    = (in_prod > fba_pkg::PROD_W'(fba_pkg::WEIGHT_ONE))
                  ? fba_pkg::WEIGHT_ONE : in_prod[fba_pkg::W_W-1:0];
    end

    // ---------------- stage a: weight, memory read issued ----------------
    logic                      a_valid_reg;
    logic [fba_pkg::IDX_W-1:0] a_idx_reg;
    fba_pkg::chan_vec_t        a_ch_reg;
    logic [fba_pkg::W_W-1:0]   a_w_reg;
    logic                      a_first_reg;
    logic                      a_last_reg;
    fba_pkg::term_vec_t        a_term;

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            a_term[k] = fba_pkg::TERM_W'(a_ch_reg[k]) * fba_pkg::TERM_W'(a_w_reg);
        end
    end

    // ---------------- stage c: read-modify-write ----------------
    logic                      c_valid_reg;
    logic [fba_pkg::IDX_W-1:0] c_idx_reg;
    fba_pkg::term_vec_t        c_term_reg;
    logic [fba_pkg::W_W-1:0]   c_w_reg;
    logic                      c_first_reg;
    logic                      c_last_reg;
    logic [ADDR_W-1:0]         c_addr;

    fba_pkg::sum_vec_t         ram_sums_rd;
    logic [fba_pkg::WT_W-1:0]  ram_wt_rd;

    logic                      wr_valid_reg;
    logic [ADDR_W-1:0]         wr_addr_reg;
    fba_pkg::sum_vec_t         wr_sums_reg;
    logic [fba_pkg::WT_W-1:0]  wr_wt_reg;

    logic                      fwd_hit;
    fba_pkg::sum_vec_t         old_sums;
    logic [fba_pkg::WT_W-1:0]  old_wt;
    fba_pkg::sum_vec_t         new_sums;
    logic [fba_pkg::WT_W-1:0]  new_wt;
    logic [fba_pkg::SUM_W:0]   sum_ext [NCH];
    logic [fba_pkg::WT_W:0]    wt_ext;

    assign c_addr = ADDR_W'(c_idx_reg);
    // the write of the item just ahead lands in the same cycle as this read
    assign fwd_hit = wr_valid_reg && (wr_addr_reg == c_addr);

    always_comb
    begin
        old_sums = fwd_hit ? wr_sums_reg : ram_sums_rd;
        old_wt   = fwd_hit ? wr_wt_reg : ram_wt_rd;
        for (int k = 0; k < NCH; k++)
        begin
            sum_ext[k] = {1'b0, old_sums[k]} + (fba_pkg::SUM_W + 1)'(c_term_reg[k]);
            if (c_first_reg)
            begin
                new_sums[k] = fba_pkg::SUM_W'(c_term_reg[k]);
            end
            else if (sum_ext[k][fba_pkg::SUM_W])
            begin
                new_sums[k] = '1;
            end
            else
            begin
                new_sums[k] = sum_ext[k][fba_pkg::SUM_W-1:0];
            end
        end
        wt_ext = {1'b0, old_wt} + (fba_pkg::WT_W + 1)'(c_w_reg);
        if (c_first_reg)
        begin
            new_wt = fba_pkg::WT_W'(c_w_reg);
        end
        else if (wt_ext[fba_pkg::WT_W])
        begin
            new_wt = '1;
        end
        else
        begin
            new_wt = wt_ext[fba_pkg::WT_W-1:0];
        end
    end

    fba_ram #(
        .WIDTH (NCH * fba_pkg::SUM_W),
        .DEPTH (FRAME_PIXELS)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (c_valid_reg),
        .wr_addr (c_addr),
        .wr_data (new_sums),
        .rd_addr (ADDR_W'(a_idx_reg)),
        .rd_data (ram_sums_rd)
    );

    fba_ram #(
        .WIDTH (fba_pkg::WT_W),
        .DEPTH (FRAME_PIXELS)
    ) u_wt_ram (
        .clk     (clk),
        .wr_en   (c_valid_reg),
        .wr_addr (c_addr),
        .wr_data (new_wt),
        .rd_addr (ADDR_W'(a_idx_reg)),
        .rd_data (ram_wt_rd)
    );

    // ---------------- stage p and q: divider operands ----------------
    logic                      p_valid_reg;
    logic [fba_pkg::IDX_W-1:0] p_idx_reg;
    fba_pkg::sum_vec_t         p_sums_reg;
    logic [fba_pkg::WT_W-1:0]  p_wt_reg;
    logic [fba_pkg::DEN_W-1:0] p_den;
    fba_pkg::num_vec_t         p_num;

    always_comb
    begin
        p_den = fba_pkg::DEN_W'(p_wt_reg) + fba_pkg::DEN_W'(1);
        for (int k = 0; k < NCH; k++)
        begin
            p_num[k] = fba_pkg::NUM_W'({p_sums_reg[k], 1'b0})
                       + fba_pkg::NUM_W'(p_den);
        end
    end

    logic                      q_valid_reg;
    logic [fba_pkg::IDX_W-1:0] q_idx_reg;
    fba_pkg::num_vec_t         q_num_reg;
    logic [fba_pkg::DIV_W-1:0] q_div_reg;

    // ---------------- divider: overflow check, then one quotient bit a stage
    logic                      dv_valid_reg [NDS];
    logic [fba_pkg::IDX_W-1:0] dv_idx_reg   [NDS];
    logic [fba_pkg::DIV_W-1:0] dv_div_reg   [NDS];
    fba_pkg::num_vec_t         dv_rem_reg   [NDS];
    fba_pkg::chan_vec_t        dv_q_reg     [NDS];
    logic [NCH-1:0]            dv_ovf_reg   [NDS];
    fba_pkg::num_vec_t         dv_rem_next  [NDS];
    fba_pkg::chan_vec_t        dv_q_next    [NDS];
    logic [NCH-1:0]            dv_ovf_next  [NDS];
    logic [fba_pkg::NUM_W-1:0] dv_shifted;

    always_comb
    begin
        dv_shifted = '0;
        for (int s = 0; s < NDS; s++)
        begin
            if (s == 0)
            begin
                dv_shifted = fba_pkg::NUM_W'(q_div_reg) << fba_pkg::CH_W;
                for (int k = 0; k < NCH; k++)
                begin
                    dv_rem_next[s][k] = q_num_reg[k];
                    dv_q_next[s][k]   = '0;
                    dv_ovf_next[s][k] = (q_num_reg[k] >= dv_shifted);
                end
            end
            else
            begin
                dv_shifted = fba_pkg::NUM_W'(dv_div_reg[s-1]) << (NDS - 1 - s);
                for (int k = 0; k < NCH; k++)
                begin
                    dv_ovf_next[s][k] = dv_ovf_reg[s-1][k];
                    dv_q_next[s][k]   = dv_q_reg[s-1][k];
                    dv_rem_next[s][k] = dv_rem_reg[s-1][k];
                    if (dv_rem_reg[s-1][k] >= dv_shifted)
                    begin
                        dv_rem_next[s][k] = dv_rem_reg[s-1][k] - dv_shifted;
                        dv_q_next[s][k][NDS - 1 - s] = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------- output fifo and credit count ----------------
    fba_pkg::result_t   fifo_mem_reg [fba_pkg::OUT_FIFO_DEPTH];
    logic [FIFO_AW:0]   fifo_wr_ptr_reg;
    logic [FIFO_AW:0]   fifo_rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_count;
    logic [CNT_W-1:0]   pending_reg;
    logic               fifo_push;
    logic               fifo_pop;
    fba_pkg::result_t   push_item;
    fba_pkg::result_t   head_item;
    logic               credit_take;

    assign fifo_push   = dv_valid_reg[NDS-1];
    assign fifo_pop    = m_axis_tvalid && m_axis_tready;
    assign fifo_count  = fifo_wr_ptr_reg - fifo_rd_ptr_reg;
    assign credit_take = in_accept && s_axis_tlast && in_frame;

    always_comb
    begin
        push_item.idx = dv_idx_reg[NDS-1];
        for (int k = 0; k < NCH; k++)
        begin
            push_item.ch[k] = dv_ovf_reg[NDS-1][k] ? '1 : dv_q_reg[NDS-1][k];
        end
    end

    assign head_item     = fifo_mem_reg[fifo_rd_ptr_reg[FIFO_AW-1:0]];
    assign m_axis_tvalid = (fifo_wr_ptr_reg != fifo_rd_ptr_reg);
    assign m_axis_tdata  = {head_item.ch[2], head_item.ch[1], head_item.ch[0],
                            head_item.idx};
    assign s_axis_tready = (pending_reg < CNT_W'(fba_pkg::OUT_FIFO_DEPTH));

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharpness_reg   <= fba_pkg::SHARPNESS_RESET;
            a_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            wr_valid_reg    <= 1'b0;
            p_valid_reg     <= 1'b0;
            q_valid_reg     <= 1'b0;
            for (int s = 0; s < NDS; s++)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            pending_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sharpness_reg <= cfg_data;
            end
            a_valid_reg  <= in_accept && in_frame;
            c_valid_reg  <= a_valid_reg;
            wr_valid_reg <= c_valid_reg;
            p_valid_reg  <= c_valid_reg && c_last_reg;
            q_valid_reg  <= p_valid_reg;
            dv_valid_reg[0] <= q_valid_reg;
            for (int s = 1; s < NDS; s++)
            begin
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            end
            if (fifo_push)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + (FIFO_AW + 1)'(1);
            end
            if (fifo_pop)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + (FIFO_AW + 1)'(1);
            end
            unique case ({credit_take, fifo_pop})
                2'b10:   pending_reg <= pending_reg + CNT_W'(1);
                2'b01:   pending_reg <= pending_reg - CNT_W'(1);
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_idx_reg   <= in_idx;
            a_ch_reg    <= in_ch;
            a_w_reg     <= in_w;
            a_first_reg <= s_axis_tuser;
            a_last_reg  <= s_axis_tlast;
        end
        c_idx_reg   <= a_idx_reg;
        c_term_reg  <= a_term;
        c_w_reg     <= a_w_reg;
        c_first_reg <= a_first_reg;
        c_last_reg  <= a_last_reg;

        wr_addr_reg <= c_addr;
        wr_sums_reg <= new_sums;
        wr_wt_reg   <= new_wt;

        p_idx_reg  <= c_idx_reg;
        p_sums_reg <= new_sums;
        p_wt_reg   <= new_wt;

        q_idx_reg <= p_idx_reg;
        q_num_reg <= p_num;
        q_div_reg <= {p_den, 1'b0};

        dv_idx_reg[0] <= q_idx_reg;
        dv_div_reg[0] <= q_div_reg;
        for (int s = 1; s < NDS; s++)
        begin
            dv_idx_reg[s] <= dv_idx_reg[s-1];
            dv_div_reg[s] <= dv_div_reg[s-1];
        end
        for (int s = 0; s < NDS; s++)
        begin
            dv_rem_reg[s] <= dv_rem_next[s];
            dv_q_reg[s]   <= dv_q_next[s];
            dv_ovf_reg[s] <= dv_ovf_next[s];
        end

        if (fifo_push)
        begin
            fifo_mem_reg[fifo_wr_ptr_reg[FIFO_AW-1:0]] <= push_item;
        end
    end

    // ---------------- assertions ----------------
    `FBA_ASSERT(a_credit_bound,
        pending_reg <= CNT_W'(fba_pkg::OUT_FIFO_DEPTH),
        "outstanding result count above fifo depth")
    `FBA_ASSERT(a_fifo_within_credit,
        (CNT_W + 1)'(fifo_count) <= (CNT_W + 1)'(pending_reg),
        "output fifo holds more results than credits taken")
    `FBA_ASSERT(a_push_not_full,
        fifo_push |-> (fifo_count < (FIFO_AW + 1)'(fba_pkg::OUT_FIFO_DEPTH)),
        "result pushed into a full output fifo")
    `FBA_ASSERT(a_result_follows_last,
        p_valid_reg |-> ($past(c_valid_reg) && $past(c_last_reg)),
        "divider fed by an item that was not a last image")

endmodule

// ===== sim/feather_blend_accumulator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// feather_blend_accumulator_test
// self-checking bench for the feather blend accumulator: pixel transactions
// go in on s_axis, and a scoreboard keeps its own per-pixel weighted sums.
// It predicts each normalised pixel and compares it field by field with
// m_axis. A directed opening is followed by randomly interleaved image
// sequences under several sharpness settings, with random idling on both
// sides and one long output stall.
// ---------------------------------------------------------------------------
module feather_blend_accumulator_test;
    import fba_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 4;
    // comfortably beyond the pipeline latency
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_IMAGES    = 16;
    localparam int OPEN_SEQS     = 4;

    localparam logic [SHARP_W-1:0] SHARP_MAX   = '1;
    localparam logic [SHARP_W-1:0] SHARP_UNITY = 24'h010000;

    typedef struct packed {
        logic              last_img;
        logic              first_img;
        logic [DIST_W-1:0] edge_dist;
        chan_vec_t         ch;
        logic [IDX_W-1:0]  idx;
    } pixel_item_t;

    class blend_scoreboard;
        bit [SUM_W-1:0]     ch_sums [FRAME_PIXELS_DEF * NUM_CH];
        bit [WT_W-1:0]      wt_sums [FRAME_PIXELS_DEF];
        result_t            blend_due [$];
        logic [SHARP_W-1:0] sharp_q        = SHARPNESS_RESET;
        int unsigned        mismatches     = 0;
        int unsigned        pixels_seen    = 0;
        int unsigned        blends_checked = 0;
        int unsigned        saturations    = 0;

        function int pending();
            return blend_due.size();
        endfunction

        // fold one pixel into its sums and queue the blended pixel on a last image
        function void note_input(pixel_item_t it);
            logic [PROD_W-1:0] prod;
            logic [W_W-1:0]    w;
            logic [SUM_W:0]    ch_sum;
            logic [WT_W:0]     wt_sum;
            longint unsigned   den;
            longint unsigned   quot;
            int                slot;
            result_t           res;

            pixels_seen++;
            slot = int'(it.idx) * NUM_CH;
            prod = PROD_W'(it.edge_dist) * PROD_W'(sharp_q);
            w = (prod > PROD_W'(WEIGHT_ONE)) ? WEIGHT_ONE : prod[W_W-1:0];

            for (int k = 0; k < NUM_CH; k++)
            begin
                ch_sum = (SUM_W + 1)'(it.ch[k]) * (SUM_W + 1)'(w);
                if (!it.first_img)
                    ch_sum += (SUM_W + 1)'(ch_sums[slot + k]);
                if (ch_sum[SUM_W])
                begin
                    ch_sums[slot + k] = '1;
                    saturations++;
                end
                else
                    ch_sums[slot + k] = ch_sum[SUM_W-1:0];
            end

            wt_sum = (WT_W + 1)'(w);
            if (!it.first_img)
                wt_sum += (WT_W + 1)'(wt_sums[it.idx]);
            if (wt_sum[WT_W])
            begin
                wt_sums[it.idx] = '1;
                saturations++;
            end
            else
                wt_sums[it.idx] = wt_sum[WT_W-1:0];

            if (it.last_img)
            begin
                // one lsb added to the weight total keeps the divisor nonzero, so a zero total weight blends to zero
                den = 64'(wt_sums[it.idx]) + 64'd1;
                res.idx = it.idx;
                for (int k = 0; k < NUM_CH; k++)
                begin
                    quot = (64'd2 * 64'(ch_sums[slot + k]) + den) / (64'd2 * den);
                    res.ch[k] = (quot > 64'd255) ? {CH_W{1'b1}} : quot[CH_W-1:0];
                end
                blend_due.push_back(res);
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch %0d at %0t ns: %s", mismatches, $time, what);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] tdata);
            logic [IDX_W-1:0] got_idx;
            chan_vec_t        got_ch;
            result_t          want;

            got_idx = tdata[IDX_W-1:0];
            got_ch  = tdata[IDX_W +: NUM_CH * CH_W];
            blends_checked++;
            if (blend_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected blended pixel at index %0d", got_idx));
                return;
            end
            want = blend_due.pop_front();
            if (got_idx !== want.idx)
                report_mismatch($sformatf("index %0d, expected %0d", got_idx, want.idx));
            for (int k = 0; k < NUM_CH; k++)
                if (got_ch[k] !== want.ch[k])
                    report_mismatch($sformatf("pixel %0d channel %0d: %0d, expected %0d",
                                              want.idx, k, got_ch[k], want.ch[k]));
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [SHARP_W-1:0]    cfg_data      = '0;

    blend_scoreboard blend_sb = new;

    bit          src_idle_en     = 1'b1;
    bit          sink_idle_en    = 1'b1;
    bit          sink_hold       = 1'b0;
    bit          hold_go         = 1'b0;
    int unsigned sink_stall_left = 0;
    int unsigned settings_used   = 0;

    // pixels that a first image has written, so later images may accumulate
    bit px_written [int];
    int written_px [$];
    // open image sequences, one entry per pixel being built up
    int seq_px      [$];
    int seq_left    [$];
    bit seq_started [$];
    bit seq_hot     [$];

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    feather_blend_accumulator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // output side: random stalls, plus the long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n || sink_hold)
            m_axis_tready <= 1'b0;
        else if (sink_stall_left != 0)
        begin
            sink_stall_left <= sink_stall_left - 1;
            m_axis_tready   <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 7) == 0)
        begin
            sink_stall_left <= $urandom_range(0, 18);
            m_axis_tready   <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin : hold_off
        int unsigned held;
        while (!hold_go)
            @(posedge clk);
        sink_hold <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            blend_sb.note_input(pixel_item_t'({s_axis_tlast, s_axis_tuser,
                                               s_axis_tdata[$bits(pixel_item_t)-3:0]}));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            blend_sb.check_result(m_axis_tdata);
    end

    initial
    begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("run stopped after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic pixel_item_t make_pixel(input logic [IDX_W-1:0] idx,
                                               input logic [CH_W-1:0] c0, c1, c2,
                                               input logic [DIST_W-1:0] edge_dist,
                                               input logic first_img, last_img);
        pixel_item_t it;
        it.idx       = idx;
        it.ch[0]     = c0;
        it.ch[1]     = c1;
        it.ch[2]     = c2;
        it.edge_dist = edge_dist;
        it.first_img = first_img;
        it.last_img  = last_img;
        return it;
    endfunction

    // hot pixels carry bright channels and mostly the largest edge distance to drive the sums into saturation
    function automatic pixel_item_t random_pixel(input int idx, input bit hot);
        pixel_item_t it;
        it.idx = IDX_W'(idx);
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (hot)
                it.ch[k] = CH_W'($urandom_range(224, 255));
            else
                case ($urandom_range(0, 5))
                    0:       it.ch[k] = '0;
                    1:       it.ch[k] = '1;
                    default: it.ch[k] = CH_W'($urandom_range(0, 255));
                endcase
        end
        case ($urandom_range(0, 7))
            0:       it.edge_dist = hot ? '1 : '0;
            1:       it.edge_dist = '1;
            2:       it.edge_dist = DIST_W'($urandom_range(1, 8));
            default: it.edge_dist = hot ? '1 : DIST_W'($urandom_range(0, 1023));
        endcase
        it.first_img = 1'b0;
        it.last_img  = 1'b0;
        return it;
    endfunction

    task automatic push_pixel(input pixel_item_t it);
        if (src_idle_en && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({it.edge_dist, it.ch, it.idx});
        s_axis_tuser  <= it.first_img;
        s_axis_tlast  <= it.last_img;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (it.first_img && !px_written.exists(int'(it.idx)))
        begin
            px_written[int'(it.idx)] = 1'b1;
            written_px.push_back(int'(it.idx));
        end
    endtask

    task automatic write_sharpness(input logic [SHARP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        blend_sb.sharp_q = value;
        settings_used++;
    endtask

    // wait for every blended pixel, then let trailing non-emitting pixels clear
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (blend_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic blend_phase(input int unsigned n_items, input int unsigned max_imgs,
                               input bit noisy);
        int unsigned sent;
        int unsigned slot;
        int unsigned roll;
        bit          hot;
        pixel_item_t it;

        sent = 0;
        seq_px.delete();
        seq_left.delete();
        seq_started.delete();
        seq_hot.delete();
        while (sent < n_items)
        begin
            if (seq_px.size() == 0 || (seq_px.size() < OPEN_SEQS && $urandom_range(0, 3) == 0))
            begin
                hot = (max_imgs > 1 && $urandom_range(0, 11) == 0);
                seq_px.push_back(int'($urandom_range(0, 65535)));
                seq_left.push_back(hot ? int'($urandom_range(33, 40))
                                       : int'($urandom_range(1, max_imgs)));
                seq_started.push_back(1'b0);
                seq_hot.push_back(hot);
            end
            slot = $urandom_range(0, seq_px.size() - 1);
            roll = noisy ? $urandom_range(0, 19) : 19;
            if (roll == 0 && !seq_hot[slot])
            begin
                // broken sequence: dropped before its last image
                seq_px.delete(slot);
                seq_left.delete(slot);
                seq_started.delete(slot);
                seq_hot.delete(slot);
            end
            else if (roll <= 2 && written_px.size() != 0)
            begin
                // stray extra image or early emit on a pixel already written
                it = random_pixel(written_px[$urandom_range(0, written_px.size() - 1)], 1'b0);
                it.last_img = 1'($urandom_range(0, 1));
                push_pixel(it);
                sent++;
            end
            else if (roll == 3)
            begin
                it = random_pixel(int'($urandom_range(0, 65535)), 1'b0);
                it.first_img = 1'b1;
                it.last_img  = 1'($urandom_range(0, 1));
                push_pixel(it);
                sent++;
            end
            else
            begin
                it = random_pixel(seq_px[slot], seq_hot[slot]);
                it.first_img = !seq_started[slot];
                it.last_img  = (seq_left[slot] == 1);
                push_pixel(it);
                sent++;
                seq_started[slot] = 1'b1;
                seq_left[slot]    = seq_left[slot] - 1;
                if (seq_left[slot] == 0)
                begin
                    seq_px.delete(slot);
                    seq_left.delete(slot);
                    seq_started.delete(slot);
                    seq_hot.delete(slot);
                end
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sharpness still at its reset value
        push_pixel(make_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 1'b1));
        push_pixel(make_pixel(16'hFFFF, 8'd255, 8'd255, 8'd255, 10'd1023, 1'b1, 1'b1));
        push_pixel(make_pixel(16'h1234, 8'd255, 8'd0, 8'd128, 10'd1, 1'b1, 1'b0));
        // weight clipped to one
        push_pixel(make_pixel(16'h1234, 8'd0, 8'd255, 8'd7, 10'd50, 1'b0, 1'b0));
        push_pixel(make_pixel(16'h1234, 8'd9, 8'd9, 8'd9, 10'd0, 1'b0, 1'b1));
        // back-to-back images of one pixel, emitted twice
        push_pixel(make_pixel(16'hA5C3, 8'd17, 8'd34, 8'd51, 10'd3, 1'b1, 1'b1));
        push_pixel(make_pixel(16'hA5C3, 8'd200, 8'd100, 8'd50, 10'd1000, 1'b0, 1'b1));
        // zero total weight after two images
        push_pixel(make_pixel(16'h5A3C, 8'd1, 8'd2, 8'd3, 10'd0, 1'b1, 1'b0));
        push_pixel(make_pixel(16'h5A3C, 8'd4, 8'd5, 8'd6, 10'd0, 1'b0, 1'b1));
        settle();

        // weight equals distance: half-way quotients round upwards
        write_sharpness(24'd1);
        push_pixel(make_pixel(16'h5555, 8'd3, 8'd1, 8'd255, 10'd1, 1'b1, 1'b1));
        push_pixel(make_pixel(16'hAAAA, 8'd254, 8'd128, 8'd1, 10'd1023, 1'b1, 1'b0));
        push_pixel(make_pixel(16'hAAAA, 8'd1, 8'd127, 8'd254, 10'd1, 1'b0, 1'b1));
        settle();

        write_sharpness('0);
        push_pixel(make_pixel(16'h00FF, 8'd255, 8'd255, 8'd255, 10'd1023, 1'b1, 1'b1));
        push_pixel(make_pixel(16'hFFFF, 8'd128, 8'd128, 8'd128, 10'd1023, 1'b0, 1'b1));
        settle();

        write_sharpness(SHARP_MAX);
        push_pixel(make_pixel(16'hFF00, 8'd255, 8'd0, 8'd255, 10'd1, 1'b1, 1'b1));
        push_pixel(make_pixel(16'h0F0F, 8'd100, 8'd200, 8'd50, 10'd1023, 1'b1, 1'b0));
        push_pixel(make_pixel(16'h0F0F, 8'd100, 8'd200, 8'd50, 10'd1023, 1'b0, 1'b1));

        blend_phase(170, 6, 1'b1);
        settle();
        write_sharpness(SHARP_W'($urandom_range(1, SHARP_MAX)));
        blend_phase(150, MAX_IMAGES, 1'b1);
        settle();
        write_sharpness('0);
        blend_phase(60, 4, 1'b1);
        settle();
        write_sharpness(SHARP_W'($urandom_range(1, 4000)));
        blend_phase(170, MAX_IMAGES, 1'b1);
        settle();

        // single-image pixels back to back while the output is held off
        write_sharpness(SHARP_UNITY);
        src_idle_en = 1'b0;
        hold_go <= 1'b1;
        blend_phase(130, 1, 1'b0);
        settle();

        write_sharpness(SHARPNESS_RESET);
        sink_idle_en <= 1'b0;
        blend_phase(200, 8, 1'b1);
        settle();

        $display("covered %0d pixel transactions and %0d blended pixels over %0d sharpness settings",
                 blend_sb.pixels_seen, blend_sb.blends_checked, settings_used + 1);
        $display("saturating sums: %0d; output held off once for %0d cycles",
                 blend_sb.saturations, HOLD_CYCLES);
        if (blend_sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fba_pkg.sv
src/fba_ram.sv
src/feather_blend_accumulator.sv
sim/feather_blend_accumulator_test.sv
